>>> design/u2d_pkg.sv
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared widths, constants and controller/datapath interface types for the
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package u2d_pkg;

  localparam int BIN_W      = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(BIN_W);
  localparam int CHAR_W     = 6;

  // one double-dabble step per binary bit
  localparam int CONV_STEPS = BIN_W;

  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = DIGIT_W'(3);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;   // capture input word, clear BCD
    logic             shift;  // one correct-and-shift step
    logic             emit;   // load output register with digit idx
    logic [IDX_W-1:0] idx;
    logic             last;
  } u2d_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [IDX_W-1:0] lead;      // highest nonzero digit, 0 if all zero
    logic             oreg_free;
  } u2d_sts_t;

endpackage

>>> design/u2d_dp.sv
// ----------------------------------------------------------------------------
// u2d_dp
// Datapath: shift-and-add-three register pair, leading digit detect and the
// output word register.
// ----------------------------------------------------------------------------
module u2d_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [u2d_pkg::BIN_W-1:0]          in_value,
  input  u2d_pkg::u2d_cmd_t                  cmd,
  output u2d_pkg::u2d_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [u2d_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                               out_last
);
  import u2d_pkg::*;

  logic [BIN_W-1:0]  bin_r, bin_nxt;
  bcd_t              bcd_r, bcd_nxt;
  bcd_t              adj;
  logic              oval_r;
  logic [CHAR_W-1:0] ochar_r;
  logic              olast_r;
  logic [IDX_W-1:0]  lead;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= DABBLE_LIMIT) ? bcd_r[i] + DABBLE_ADJ : bcd_r[i];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (cmd.load) begin
      bin_nxt = in_value;
      bcd_nxt = '0;
    end else if (cmd.shift) begin
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      bcd_nxt = BCD_W'({adj, bin_r[BIN_W-1]});
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  // priority pick of the most significant nonzero digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != '0) lead = IDX_W'(i);
    end
  end

  assign sts.lead      = lead;
  assign sts.oreg_free = !oval_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.emit) begin
      oval_r <= 1'b1;
    end else if (!out_stall) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ochar_r <= ASCII_ZERO + CHAR_W'(bcd_r[cmd.idx]);
      olast_r <= cmd.last;
    end
  end

  assign out_valid      = oval_r;
  assign out_digit_char = ochar_r;
  assign out_last       = olast_r;

endmodule

>>> design/u2d_ctrl.sv
// ----------------------------------------------------------------------------
// u2d_ctrl
// Controller: sequences capture, 32 conversion steps, leading digit lookup
// and the digit-by-digit output run.
// ----------------------------------------------------------------------------
module u2d_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  u2d_pkg::u2d_sts_t sts,
  output u2d_pkg::u2d_cmd_t cmd
);
  import u2d_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_LEAD = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.last  = (idx_r == '0);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) state_nxt = S_LEAD;
      end
      S_LEAD: begin
        idx_nxt   = sts.lead;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.oreg_free) begin
          cmd.emit = 1'b1;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> design/uint32_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// uint32_to_decimal_ascii
// Converts an unsigned 32-bit word to its decimal digits in ASCII, most
// significant first, leading zeros dropped, last digit marked.
// ----------------------------------------------------------------------------
//  channel | ports                                   | word
//  --------+-----------------------------------------+---------------------
//  in      | in_valid, in_stall, in_value            | 32-bit binary value
//  out     | out_valid, out_stall, out_digit_char,   | one ASCII digit,
//          | out_last                                | last on final digit
//
// One word is captured, put through 32 shift-and-add-three steps in the
// datapath and a leading digit lookup, then sent one digit per cycle while
// the output does not stall. The converter holds one word at a
// time; the next input is taken once the final digit sits in the output
// register. Output stalls hold the output register and pause the digit run.
// Synchronous active-low reset clears the controller and the output valid.
// ----------------------------------------------------------------------------
module uint32_to_decimal_ascii (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [u2d_pkg::BIN_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [u2d_pkg::CHAR_W-1:0] out_digit_char,
  output logic                       out_last
);
  import u2d_pkg::*;

  u2d_cmd_t cmd;
  u2d_sts_t sts;

  u2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  u2d_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  // never overwrite a word still waiting at the output
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.oreg_free)
    else $error("digit emitted over a pending output word");

  // after an accept the converter is busy
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a conversion runs");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (cmd.idx <= IDX_W'(NUM_DIGITS - 1)))
    else $error("digit index out of range");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && (cmd.shift || cmd.emit)))
    else $error("load overlaps shift or emit");
`endif

endmodule
